[rtl/circle_rect_collision_push_top_defines.svh]
// Assertion macros for the circle and rectangle collision block.
// Included by the top level; needs nothing else.
`ifndef CIRCLE_RECT_COLLISION_PUSH_TOP_DEFINES_SVH
`define CIRCLE_RECT_COLLISION_PUSH_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// General form with an explicit clock and active-low reset.
`define CRCP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Short form on the block clock and reset.
`define CRCP_ASSERT_CLK(lbl, prop, msg) \
  `CRCP_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`else

`define CRCP_ASSERT(lbl, clk, rstn, prop, msg)
`define CRCP_ASSERT_CLK(lbl, prop, msg)

`endif

`endif

[rtl/crcp_pkg.sv]
// Constants, types and helper functions for the circle and rectangle collision block.
// Depends on nothing; used by circle_rect_collision_push_top.
package crcp_pkg;

  // Fixed-point format and field widths.
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned COORD_W    = 24;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned SQRT_XBITS = 12;

  // Internal widths, lengths in half-LSB units.
  localparam int unsigned HW     = 27;  // coordinates and edges
  localparam int unsigned MAGW   = 17;  // near-distance magnitude and radius
  localparam int unsigned SQW    = 34;  // one square
  localparam int unsigned D2W    = 35;  // squared distance
  localparam int unsigned NW     = 58;  // root operand
  localparam int unsigned SQ_STEPS = 29;
  localparam int unsigned SW     = 30;  // root value
  localparam int unsigned DENW   = 31;
  localparam int unsigned PRODW  = 47;
  localparam int unsigned NUMW   = 48;
  localparam int unsigned REMW   = 32;

  // Squared-distance threshold for the inside case, in LSBs squared.
  localparam longint unsigned EPS_SQ = (64'd1 << (2 * FRAC_BITS)) / 64'd10000;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_CX = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_CY = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_W  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_H  = 4'd3;

  // Result candidate that travels along the pipeline.
  typedef struct packed {
    logic                      hit;
    logic                      outside;
    logic                      xneg;
    logic                      yneg;
    logic [COORD_W-1:0]        in_px;
    logic [COORD_W-1:0]        in_py;
  } crcp_res_t;

  // One stage of the square root.
  typedef struct packed {
    crcp_res_t                 res;
    logic [MAGW-1:0]           adx;
    logic [MAGW-1:0]           ady;
    logic [MAGW-1:0]           rad;
    logic [NW-1:0]             n;
    logic [NW-1:0]             root;
  } crcp_sqrt_t;

  // One stage of the two dividers.
  typedef struct packed {
    crcp_res_t                 res;
    logic [DENW-1:0]           den;
    logic [NUMW-1:0]           num_x;
    logic [NUMW-1:0]           num_y;
    logic [NUMW-1:0]           q_x;
    logic [NUMW-1:0]           q_y;
    logic [REMW-1:0]           rem_x;
    logic [REMW-1:0]           rem_y;
  } crcp_div_t;

  // Signed push from sign and magnitude, saturated to the output range.
  function automatic logic [COORD_W-1:0] sat_push(logic neg, logic [NUMW-1:0] mag);
    logic [NUMW-1:0] neg_mag;
    neg_mag = (~mag) + NUMW'(1);
    if (neg) begin
      return (mag > NUMW'(64'd8388608)) ? 24'h800000 : neg_mag[COORD_W-1:0];
    end else begin
      return (mag > NUMW'(64'd8388607)) ? 24'h7FFFFF : mag[COORD_W-1:0];
    end
  endfunction

endpackage

[rtl/circle_rect_collision_push_top.sv]
// Circle against axis-aligned rectangle test with push-out vector, fully pipelined.
// Depends on crcp_pkg and circle_rect_collision_push_top_defines.svh.
//
// Channel  Dir  Handshake              Content
// s_axis   in   tvalid/tready          circle_x, circle_y, circle_rad
// m_axis   out  tvalid/tready          hit, push_x, push_y
// cfg      in   cfg_valid_i/ready_o    register index, write data
//
// One item enters per cycle while the output is not held; the 29-stage square
// root and the 48-stage dividers produce one result bit per stage.
// Reset clears the valid bits and the rectangle registers; the pipeline is empty.
// When the output item is not taken the whole pipeline holds, and input
// ready drops until it moves again. Configuration writes are always taken.
`include "circle_rect_collision_push_top_defines.svh"

module circle_rect_collision_push_top #(
  parameter int unsigned FRAC_BITS = crcp_pkg::FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // circle_x [23:0], circle_y [47:24], circle_rad [63:48]
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // hit [0], push_x [24:1], push_y [48:25], zero [55:49]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [crcp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  localparam int unsigned HW   = crcp_pkg::HW;
  localparam int unsigned MAGW = crcp_pkg::MAGW;
  localparam int unsigned NW   = crcp_pkg::NW;
  localparam int unsigned SQS  = crcp_pkg::SQ_STEPS;
  localparam int unsigned NUMW = crcp_pkg::NUMW;
  localparam int unsigned REMW = crcp_pkg::REMW;
  localparam int unsigned DENW = crcp_pkg::DENW;
  localparam int unsigned SW   = crcp_pkg::SW;
  localparam int unsigned D2W  = crcp_pkg::D2W;

  // Inside threshold, in half-LSB units squared.
  localparam longint unsigned EPS_SQ = (64'd1 << (2 * FRAC_BITS)) / 64'd10000;
  localparam logic [D2W-1:0] EPS4 = D2W'(4 * EPS_SQ);

  // Rectangle registers.
  logic [23:0] rect_cx_q, rect_cy_q;
  logic [15:0] rect_w_q, rect_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_cx_q <= '0;
      rect_cy_q <= '0;
      rect_w_q  <= '0;
      rect_h_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        crcp_pkg::REG_RECT_CX: rect_cx_q <= cfg_data_i;
        crcp_pkg::REG_RECT_CY: rect_cy_q <= cfg_data_i;
        crcp_pkg::REG_RECT_W:  rect_w_q  <= cfg_data_i[15:0];
        crcp_pkg::REG_RECT_H:  rect_h_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Pipeline enable: everything moves unless the output item waits.
  logic en;
  logic vf_q;
  assign en            = !vf_q || m_axis_tready;
  assign s_axis_tready = en;

  // Valid bits.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic [SQS-1:0]  sv_q;
  logic [NUMW-1:0] dval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0;
      sv_q <= '0;
      dval_q <= '0;
      vf_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      sv_q <= {sv_q[SQS-2:0], v4_q};
      v5_q <= sv_q[SQS-1];
      v6_q <= v5_q;
      v7_q <= v6_q;
      dval_q <= {dval_q[NUMW-2:0], v7_q};
      vf_q <= dval_q[NUMW-1];
    end
  end

  // Stage 1: doubled circle centre, radius and rectangle edges.
  logic signed [HW-1:0] cx1_q, cy1_q, left1_q, right1_q, top1_q, bot1_q;
  logic [MAGW-1:0]      rad1_q;
  logic signed [HW-1:0] cx1_d, cy1_d, rcx2, rcy2, w_ext, h_ext;

  always_comb begin
    cx1_d = $signed({{2{s_axis_tdata[23]}}, s_axis_tdata[23:0], 1'b0});
    cy1_d = $signed({{2{s_axis_tdata[47]}}, s_axis_tdata[47:24], 1'b0});
    rcx2  = $signed({{2{rect_cx_q[23]}}, rect_cx_q, 1'b0});
    rcy2  = $signed({{2{rect_cy_q[23]}}, rect_cy_q, 1'b0});
    w_ext = $signed({{(HW-16){1'b0}}, rect_w_q});
    h_ext = $signed({{(HW-16){1'b0}}, rect_h_q});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx1_q    <= cx1_d;
      cy1_q    <= cy1_d;
      rad1_q   <= {s_axis_tdata[63:48], 1'b0};
      left1_q  <= rcx2 - w_ext;
      right1_q <= rcx2 + w_ext;
      top1_q   <= rcy2 - h_ext;
      bot1_q   <= rcy2 + h_ext;
    end
  end

  // Stage 2: offsets from the nearest point and distances to each edge.
  logic signed [HW-1:0] clx, cly, dx, dy, el, er, et, eb;
  logic [HW-1:0]        adx_full, ady_full;
  logic [MAGW-1:0]      adx2_q, ady2_q, rad2_q;
  logic                 far2_q, xneg2_q, yneg2_q;
  logic [HW-1:0]        pl2_q, pr2_q, pt2_q, pb2_q;

  always_comb begin
    clx = (cx1_q < left1_q) ? left1_q : ((cx1_q > right1_q) ? right1_q : cx1_q);
    cly = (cy1_q < top1_q)  ? top1_q  : ((cy1_q > bot1_q)   ? bot1_q   : cy1_q);
    dx  = cx1_q - clx;
    dy  = cy1_q - cly;
    adx_full = dx[HW-1] ? HW'(-dx) : HW'(dx);
    ady_full = dy[HW-1] ? HW'(-dy) : HW'(dy);
    el = cx1_q - left1_q;
    er = right1_q - cx1_q;
    et = cy1_q - top1_q;
    eb = bot1_q - cy1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      adx2_q  <= adx_full[MAGW-1:0];
      ady2_q  <= ady_full[MAGW-1:0];
      // A component this large is beyond any radius.
      far2_q  <= (|adx_full[HW-1:MAGW]) || (|ady_full[HW-1:MAGW]);
      xneg2_q <= dx[HW-1];
      yneg2_q <= dy[HW-1];
      rad2_q  <= rad1_q;
      pl2_q   <= el[HW-1] ? HW'(-el) : HW'(el);
      pr2_q   <= er[HW-1] ? HW'(-er) : HW'(er);
      pt2_q   <= et[HW-1] ? HW'(-et) : HW'(et);
      pb2_q   <= eb[HW-1] ? HW'(-eb) : HW'(eb);
    end
  end

  // Stage 3: squares and the push toward the nearest edge.
  logic [crcp_pkg::SQW-1:0] sqx3_q, sqy3_q, rsq3_q;
  logic [MAGW-1:0]          adx3_q, ady3_q, rad3_q;
  logic                     far3_q, xneg3_q, yneg3_q;
  logic [23:0]              in_px3_q, in_py3_q;
  logic [HW-1:0]            best;
  logic [HW:0]              edge_sum;
  logic [NUMW-1:0]          edge_mag;
  logic [23:0]              in_px_d, in_py_d;

  always_comb begin
    best = pl2_q;
    if (pr2_q < best) best = pr2_q;
    if (pt2_q < best) best = pt2_q;
    if (pb2_q < best) best = pb2_q;
    edge_sum = {{(HW+1-MAGW){1'b0}}, rad2_q} + {1'b0, best} + (HW+1)'(1);
    edge_mag = NUMW'(edge_sum[HW:1]);
    in_px_d  = '0;
    in_py_d  = '0;
    // Ties go left, then right, then top, then bottom.
    if (best == pl2_q) begin
      in_px_d = crcp_pkg::sat_push(1'b1, edge_mag);
    end else if (best == pr2_q) begin
      in_px_d = crcp_pkg::sat_push(1'b0, edge_mag);
    end else if (best == pt2_q) begin
      in_py_d = crcp_pkg::sat_push(1'b1, edge_mag);
    end else begin
      in_py_d = crcp_pkg::sat_push(1'b0, edge_mag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx3_q   <= adx2_q * adx2_q;
      sqy3_q   <= ady2_q * ady2_q;
      rsq3_q   <= rad2_q * rad2_q;
      adx3_q   <= adx2_q;
      ady3_q   <= ady2_q;
      rad3_q   <= rad2_q;
      far3_q   <= far2_q;
      xneg3_q  <= xneg2_q;
      yneg3_q  <= yneg2_q;
      in_px3_q <= in_px_d;
      in_py3_q <= in_py_d;
    end
  end

  // Stage 4: squared distance, hit and region decision, root operand.
  logic [D2W-1:0]           d2;
  crcp_pkg::crcp_sqrt_t     sq4_d, sq4_q;

  always_comb begin
    d2 = {1'b0, sqx3_q} + {1'b0, sqy3_q};
    sq4_d.res.hit     = !far3_q && (d2 < {1'b0, rsq3_q});
    sq4_d.res.outside = d2 > EPS4;
    sq4_d.res.xneg    = xneg3_q;
    sq4_d.res.yneg    = yneg3_q;
    sq4_d.res.in_px   = in_px3_q;
    sq4_d.res.in_py   = in_py3_q;
    sq4_d.adx  = adx3_q;
    sq4_d.ady  = ady3_q;
    sq4_d.rad  = rad3_q;
    sq4_d.n    = {d2[NW-2*crcp_pkg::SQRT_XBITS-1:0], {(2*crcp_pkg::SQRT_XBITS){1'b0}}};
    sq4_d.root = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq4_q <= sq4_d;
    end
  end

  // Square root, one result bit per stage.
  crcp_pkg::crcp_sqrt_t sq_q [SQS];

  for (genvar k = 0; k < SQS; k++) begin : g_sqrt
    localparam logic [NW-1:0] BIT = NW'(1) << (NW - 2 - 2 * k);
    crcp_pkg::crcp_sqrt_t prev, nxt;
    logic [NW-1:0]        trial;

    if (k == 0) begin : g_first
      assign prev = sq4_q;
    end else begin : g_rest
      assign prev = sq_q[k-1];
    end

    always_comb begin
      nxt   = prev;
      trial = prev.root + BIT;
      if (prev.n >= trial) begin
        nxt.n    = prev.n - trial;
        nxt.root = (prev.root >> 1) + BIT;
      end else begin
        nxt.root = prev.root >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[k] <= nxt;
      end
    end
  end

  // Stage 5: push length in root units.
  crcp_pkg::crcp_res_t res5_q, res6_q;
  logic [MAGW-1:0]     adx5_q, ady5_q;
  logic [SW-1:0]       s5_q, pw5_q, s6_q, root_s;

  assign root_s = sq_q[SQS-1].root[SW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      res5_q <= sq_q[SQS-1].res;
      adx5_q <= sq_q[SQS-1].adx;
      ady5_q <= sq_q[SQS-1].ady;
      s5_q   <= root_s;
      pw5_q  <= {{(SW-MAGW-crcp_pkg::SQRT_XBITS){1'b0}}, sq_q[SQS-1].rad,
                 {crcp_pkg::SQRT_XBITS{1'b0}}} - root_s;
    end
  end

  // Stage 6: component times push length.
  logic [crcp_pkg::PRODW-1:0] px6_q, py6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      res6_q <= res5_q;
      s6_q   <= s5_q;
      px6_q  <= adx5_q * pw5_q;
      py6_q  <= ady5_q * pw5_q;
    end
  end

  // Stage 7: rounding term and divider operands.
  crcp_pkg::crcp_div_t dv7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv7_q.res   <= res6_q;
      dv7_q.den   <= {s6_q, 1'b0};
      dv7_q.num_x <= {1'b0, px6_q} + NUMW'(s6_q);
      dv7_q.num_y <= {1'b0, py6_q} + NUMW'(s6_q);
      dv7_q.q_x   <= '0;
      dv7_q.q_y   <= '0;
      dv7_q.rem_x <= '0;
      dv7_q.rem_y <= '0;
    end
  end

  // Restoring dividers for both components, one quotient bit per stage.
  crcp_pkg::crcp_div_t dv_q [NUMW];

  for (genvar k = 0; k < NUMW; k++) begin : g_div
    crcp_pkg::crcp_div_t prev, nxt;
    logic [REMW-1:0]     shx, shy;

    if (k == 0) begin : g_first
      assign prev = dv7_q;
    end else begin : g_rest
      assign prev = dv_q[k-1];
    end

    always_comb begin
      nxt       = prev;
      shx       = {prev.rem_x[REMW-2:0], prev.num_x[NUMW-1]};
      shy       = {prev.rem_y[REMW-2:0], prev.num_y[NUMW-1]};
      nxt.num_x = prev.num_x << 1;
      nxt.num_y = prev.num_y << 1;
      if (shx >= {{(REMW-DENW){1'b0}}, prev.den}) begin
        nxt.rem_x = shx - {{(REMW-DENW){1'b0}}, prev.den};
        nxt.q_x   = {prev.q_x[NUMW-2:0], 1'b1};
      end else begin
        nxt.rem_x = shx;
        nxt.q_x   = {prev.q_x[NUMW-2:0], 1'b0};
      end
      if (shy >= {{(REMW-DENW){1'b0}}, prev.den}) begin
        nxt.rem_y = shy - {{(REMW-DENW){1'b0}}, prev.den};
        nxt.q_y   = {prev.q_y[NUMW-2:0], 1'b1};
      end else begin
        nxt.rem_y = shy;
        nxt.q_y   = {prev.q_y[NUMW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[k] <= nxt;
      end
    end
  end

  // Final stage: pick the result and saturate.
  crcp_pkg::crcp_res_t fres;
  logic                hit_f_q;
  logic                outside_f_q;
  logic [23:0]         px_f_q, py_f_q, px_d, py_d;

  assign fres = dv_q[NUMW-1].res;

  always_comb begin
    if (!fres.hit) begin
      px_d = '0;
      py_d = '0;
    end else if (fres.outside) begin
      px_d = crcp_pkg::sat_push(fres.xneg, dv_q[NUMW-1].q_x);
      py_d = crcp_pkg::sat_push(fres.yneg, dv_q[NUMW-1].q_y);
    end else begin
      px_d = fres.in_px;
      py_d = fres.in_py;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_f_q     <= fres.hit;
      outside_f_q <= fres.outside;
      px_f_q      <= px_d;
      py_f_q      <= py_d;
    end
  end

  assign m_axis_tvalid = vf_q;
  assign m_axis_tdata  = {7'b0, py_f_q, px_f_q, hit_f_q};

  // Checks on the result and the stall path.
  `CRCP_ASSERT_CLK(a_miss_zero,
    (m_axis_tvalid && !hit_f_q) |-> (px_f_q == '0 && py_f_q == '0),
    "push is not zero on a miss")
  `CRCP_ASSERT_CLK(a_inside_axis,
    (m_axis_tvalid && hit_f_q && !outside_f_q) |-> (px_f_q == '0 || py_f_q == '0),
    "inside push has two components")
  `CRCP_ASSERT_CLK(a_stall_hold,
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready,
    "input taken while output stalls")

endmodule

[bench/tb.sv]
// Self-checking bench for circle_rect_collision_push_top: circles against a configured rectangle.
// Depends on crcp_pkg and the block RTL; computes expected hit and push per circle on its own.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 85;

  typedef struct packed {
    logic [15:0] rad;
    logic [23:0] y;
    logic [23:0] x;
  } circle_t;

  typedef struct packed {
    logic        hit;
    logic [23:0] px;
    logic [23:0] py;
  } push_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [crcp_pkg::CFG_IDX_W-1:0] cfg_index_i = crcp_pkg::REG_RECT_CX;
  logic [23:0] cfg_data_i = '0;

  circle_rect_collision_push_top i_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Rectangle as seen by the predictor.
  longint rect_cx, rect_cy, rect_w, rect_h;
  circle_t pending_circles[$];
  push_t   expected_pushes[$];
  int      errors = 0;
  bit      hold_off = 1'b0;

  function automatic longint isqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [23:0] sat24(longint v);
    return 24'(clampl(v, -8388608, 8388607));
  endfunction

  // Expected push for one circle; all lengths in half-LSB units.
  function automatic push_t predict_push(circle_t c);
    longint cx, cy, r, l, rt, t, b, dx, dy, px, py, pl, pr, pt, pb, best;
    longint unsigned d2, s, pw, den, mx, my;
    push_t p;
    cx = 2 * longint'($signed(c.x));
    cy = 2 * longint'($signed(c.y));
    r = 2 * longint'(c.rad);
    l = 2 * rect_cx - rect_w;
    rt = 2 * rect_cx + rect_w;
    t = 2 * rect_cy - rect_h;
    b = 2 * rect_cy + rect_h;
    dx = cx - clampl(cx, l, rt);
    dy = cy - clampl(cy, t, b);
    d2 = dx * dx + dy * dy;
    px = 0;
    py = 0;
    p = '0;
    if (d2 >= r * r) return p;
    if (d2 > 4 * crcp_pkg::EPS_SQ) begin
      s = isqrt(d2 << (2 * crcp_pkg::SQRT_XBITS));
      pw = (r << crcp_pkg::SQRT_XBITS) - s;
      den = 2 * s;
      mx = ((dx < 0 ? -dx : dx) * pw + s) / den;
      my = ((dy < 0 ? -dy : dy) * pw + s) / den;
      px = dx < 0 ? -longint'(mx) : longint'(mx);
      py = dy < 0 ? -longint'(my) : longint'(my);
    end else begin
      pl = cx - l;  if (pl < 0) pl = -pl;
      pr = rt - cx; if (pr < 0) pr = -pr;
      pt = cy - t;  if (pt < 0) pt = -pt;
      pb = b - cy;  if (pb < 0) pb = -pb;
      best = pl;
      if (pr < best) best = pr;
      if (pt < best) best = pt;
      if (pb < best) best = pb;
      // Ties go left, right, top, bottom in that order.
      if (best == pl) px = -((r + pl + 1) >>> 1);
      else if (best == pr) px = (r + pr + 1) >>> 1;
      else if (best == pt) py = -((r + pt + 1) >>> 1);
      else py = (r + pb + 1) >>> 1;
    end
    p.hit = 1'b1;
    p.px = sat24(px);
    p.py = sat24(py);
    return p;
  endfunction

  // Append one circle to the send queue.
  task automatic queue_circle(circle_t c);
    pending_circles = {pending_circles, c};
  endtask

  // Driver: offers queued circles with random gaps.
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_pushes = {expected_pushes, predict_push(circle_t'(s_axis_tdata))};
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0 || pending_circles.size() == 0) begin
          s_axis_tvalid <= 1'b0;
          if (send_gap > 0) send_gap <= send_gap - 1;
        end else begin
          s_axis_tdata <= pending_circles.pop_front();
          s_axis_tvalid <= 1'b1;
          send_gap <= $urandom_range(0, 5) * ($urandom_range(0, 2) == 0);
        end
      end
    end
  end

  // Monitor: random stalls on the result side, compares in order.
  int recv_gap = 0;
  always @(posedge clk_i) begin
    push_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.hit = m_axis_tdata[0];
        got.px = m_axis_tdata[24:1];
        got.py = m_axis_tdata[48:25];
        if (expected_pushes.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, got);
          errors++;
        end else begin
          want = expected_pushes.pop_front();
          if (got.hit !== want.hit) begin
            $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
            errors++;
          end
          if (got.px !== want.px) begin
            $display("%0t: push_x expected %h actual %h", $time, want.px, got.px);
            errors++;
          end
          if (got.py !== want.py) begin
            $display("%0t: push_y expected %h actual %h", $time, want.py, got.py);
            errors++;
          end
        end
      end
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        m_axis_tready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else begin
        m_axis_tready <= 1'b1;
        recv_gap <= $urandom_range(0, 5) * ($urandom_range(0, 2) == 0);
      end
    end
  end

  task automatic write_reg(logic [crcp_pkg::CFG_IDX_W-1:0] idx, logic [23:0] value);
    cfg_index_i <= idx;
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      crcp_pkg::REG_RECT_CX: rect_cx = longint'($signed(value));
      crcp_pkg::REG_RECT_CY: rect_cy = longint'($signed(value));
      crcp_pkg::REG_RECT_W:  rect_w = longint'(value[15:0]);
      crcp_pkg::REG_RECT_H:  rect_h = longint'(value[15:0]);
      default: ;
    endcase
    // A wait with valid low keeps the valid drop and the next write apart.
    @(posedge clk_i);
  endtask

  task automatic set_rect(logic [23:0] cx, logic [23:0] cy, logic [15:0] w, logic [15:0] h);
    write_reg(crcp_pkg::REG_RECT_CX, cx);
    write_reg(crcp_pkg::REG_RECT_CY, cy);
    write_reg(crcp_pkg::REG_RECT_W, 24'(w));
    write_reg(crcp_pkg::REG_RECT_H, 24'(h));
  endtask

  task automatic drain;
    wait (pending_circles.size() == 0 && !s_axis_tvalid && expected_pushes.size() == 0);
    @(posedge clk_i);
  endtask

  // Circle close to the rectangle, so most tests hit or touch.
  function automatic circle_t near_circle(logic [15:0] wmax);
    circle_t c;
    longint ox, oy;
    ox = rect_cx + longint'($urandom_range(0, 4 * wmax)) - 2 * longint'(wmax);
    oy = rect_cy + longint'($urandom_range(0, 4 * wmax)) - 2 * longint'(wmax);
    c.x = sat24(ox);
    c.y = sat24(oy);
    c.rad = 16'($urandom_range(0, 2 * wmax));
    return c;
  endfunction

  function automatic circle_t any_circle();
    return circle_t'({$urandom(), $urandom()});
  endfunction

  initial begin
    circle_t c;
    rect_cx = 0; rect_cy = 0; rect_w = 0; rect_h = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: edges, inside ties, epsilon, extremes, zero radius.
    set_rect(24'd1000, -24'sd500, 16'd400, 16'd200);
    queue_circle('{rad: 16'd0, y: -24'sd500, x: 24'd1000});
    queue_circle('{rad: 16'd100, y: -24'sd500, x: 24'd1000});
    queue_circle('{rad: 16'd50, y: -24'sd500, x: 24'd801});
    queue_circle('{rad: 16'd50, y: -24'sd500, x: 24'd1199});
    queue_circle('{rad: 16'd50, y: -24'sd599, x: 24'd1000});
    queue_circle('{rad: 16'd50, y: -24'sd401, x: 24'd1000});
    queue_circle('{rad: 16'd10, y: -24'sd500, x: 24'd1210});
    queue_circle('{rad: 16'd10, y: -24'sd500, x: 24'd1201});
    queue_circle('{rad: 16'd10, y: -24'sd398, x: 24'd1202});
    queue_circle('{rad: 16'd30, y: -24'sd380, x: 24'd1220});
    queue_circle('{rad: 16'hFFFF, y: 24'h7FFFFF, x: 24'h7FFFFF});
    queue_circle('{rad: 16'hFFFF, y: 24'h800000, x: 24'h800000});
    queue_circle('{rad: 16'hFFFF, y: -24'sd500, x: 24'd1100});
    drain();
    // Square rectangle, center exactly equidistant from all edges.
    set_rect(24'd0, 24'd0, 16'd100, 16'd100);
    queue_circle('{rad: 16'd7, y: 24'd0, x: 24'd0});
    queue_circle('{rad: 16'd7, y: 24'd50, x: 24'd50});
    queue_circle('{rad: 16'd7, y: -24'sd50, x: 24'd50});
    drain();
    // Extremes of the rectangle near the coordinate range limits.
    set_rect(24'h7FFFFF, 24'h800000, 16'hFFFF, 16'hFFFF);
    queue_circle('{rad: 16'hFFFF, y: 24'h800000, x: 24'h7FFFFF});
    queue_circle('{rad: 16'hFFFF, y: 24'h800010, x: 24'h7FFFF0});
    queue_circle('{rad: 16'h1234, y: 24'h7FFFFF, x: 24'h800000});
    drain();
    set_rect(24'h800000, 24'h7FFFFF, 16'h0, 16'h0);
    queue_circle('{rad: 16'hFFFF, y: 24'h7FFFFF, x: 24'h800000});
    queue_circle('{rad: 16'hFFFF, y: 24'h7FFF00, x: 24'h800100});
    drain();
    // Unused index must be ignored.
    write_reg(4'(crcp_pkg::REG_RECT_H + 1), 24'hABCDEF);

    // Random phases with varying rectangles.
    for (int ph = 0; ph < 8; ph++) begin
      logic [15:0] wmax;
      wmax = (ph % 3 == 0) ? 16'hFFFF : 16'(1 << $urandom_range(2, 12));
      set_rect(24'($urandom), 24'($urandom), 16'($urandom_range(0, wmax)),
               16'($urandom_range(0, wmax)));
      if (ph == 2) set_rect(24'd0, 24'd0, 16'd0, 16'd0);
      for (int k = 0; k < 180; k++) begin
        c = ($urandom_range(0, 9) == 0) ? any_circle() : near_circle(wmax);
        queue_circle(c);
      end
      // Long receiver stall while circles are still queued at the input.
      if (ph == 1) begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      drain();
    end

    drain();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl
rtl/crcp_pkg.sv
rtl/circle_rect_collision_push_top.sv
bench/tb.sv
